// ===== hdl/rbch_pkg.sv =====
// Shared types and constants for the ray/box closest-hit block.
// Used by the front stage, the entry queue, the back sequencer and the top level.
`timescale 1ns / 1ps
`default_nettype none
package rbch_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic KIND_RAY = 1'b0;
  localparam logic KIND_BOX = 1'b1;

  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic signed [WORD_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] S32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                   kind;
    logic                   last;
    logic [2:0][WORD_W-1:0] a;
    logic [2:0][WORD_W-1:0] b;
    logic [2:0]             bneg;
    logic [2:0]             bzero;
  } rbch_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } rbch_qstat_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_EV1,
    ST_EV2,
    ST_EMIT
  } rbch_state_t;

endpackage
`default_nettype wire

// ===== hdl/rbch_front.sv =====
// Input stage: takes a word, tags direction sign and zero flags, hands it on.
// Depends on rbch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbch_front import rbch_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic                     in_kind,
  input  wire logic signed [WORD_W-1:0] in_ax,
  input  wire logic signed [WORD_W-1:0] in_ay,
  input  wire logic signed [WORD_W-1:0] in_az,
  input  wire logic signed [WORD_W-1:0] in_bx,
  input  wire logic signed [WORD_W-1:0] in_by,
  input  wire logic signed [WORD_W-1:0] in_bz,
  input  wire logic                     in_last,
  input  wire rbch_qstat_t              q_stat,
  output logic                          q_push,
  output rbch_entry_t                   q_data
);

  logic        st_v_r, st_v_nxt;
  rbch_entry_t st_r, st_nxt;
  logic        acc;

  assign in_full = st_v_r & q_stat.full;
  assign acc     = in_push & ~in_full;
  assign q_push  = st_v_r & ~q_stat.full;
  assign q_data  = st_r;

  always_comb begin
    st_v_nxt = acc | (st_v_r & q_stat.full);
    st_nxt   = st_r;
    if (acc) begin
      st_nxt.kind  = in_kind;
      st_nxt.last  = in_last;
      st_nxt.a     = {in_az, in_ay, in_ax};
      st_nxt.b     = {in_bz, in_by, in_bx};
      st_nxt.bneg  = {in_bz[WORD_W-1], in_by[WORD_W-1], in_bx[WORD_W-1]};
      st_nxt.bzero = {in_bz == '0, in_by == '0, in_bx == '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_v_r <= 1'b0;
    end else begin
      st_v_r <= st_v_nxt;
    end
    st_r <= st_nxt;
  end

endmodule
`default_nettype wire

// ===== hdl/rbch_queue.sv =====
// Two-word queue between the front stage and the back sequencer.
// Depends on rbch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbch_queue import rbch_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire rbch_entry_t wdata,
  input  wire logic        pop,
  output rbch_entry_t      rdata,
  output rbch_qstat_t      stat
);

  rbch_entry_t mem [2];
  logic        wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        do_push, do_pop;

  assign stat.full  = cnt_r == 2'd2;
  assign stat.empty = cnt_r == 2'd0;
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & ~stat.empty;
  assign rdata      = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r ^ do_push;
    rp_nxt  = rp_r ^ do_pop;
    cnt_nxt = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem[wp_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/rbch_back.sv =====
// Back sequencer: reciprocal divider for ray words, shared multiplier and slab
// evaluation for box words, closest-hit tracking and the result register. Uses rbch_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rbch_back import rbch_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rbch_qstat_t q_stat,
  input  wire rbch_entry_t q_data,
  output logic             q_pop,
  input  wire logic [15:0] face_eps,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic             out_hit,
  output logic [30:0]      out_distance,
  output logic [1:0]       out_normal_axis,
  output logic             out_normal_sign
);

  localparam int unsigned QW = 2 * FRAC_BITS + 1;
  localparam int unsigned SW = $clog2(QW + 1);

  rbch_state_t st_r, st_nxt;
  rbch_entry_t cur_r;
  logic [1:0]  ax_r;
  logic [SW-1:0] stp_r;

  logic signed [WORD_W-1:0] org_r [3];
  logic signed [WORD_W-1:0] dir_r [3];
  logic signed [WORD_W-1:0] inv_r [3];
  logic [2:0] dneg_r, dzero_r;

  logic [WORD_W-1:0] rem_r;
  logic [QW-1:0]     quo_r;

  logic signed [64:0]       prod_r;
  logic signed [WORD_W-1:0] t_r [6];
  logic signed [WORD_W-1:0] lo_r [3];
  logic signed [WORD_W-1:0] tn_r, tf_r;
  logic                     miss_r;

  logic                     best_v_r;
  logic signed [WORD_W-1:0] best_d_r;
  logic [1:0]               best_ax_r;
  logic                     best_neg_r;

  logic        res_v_r;
  logic        res_hit_r;
  logic [30:0] res_d_r;
  logic [1:0]  res_ax_r;
  logic        res_neg_r;
  logic        res_load;

  // divider step
  logic [WORD_W-1:0] den;
  logic [WORD_W:0]   trial;
  logic              ge;
  logic [WORD_W-1:0] rem_nxt;
  logic [QW-1:0]     quo_fin;
  logic [63:0]       qx;
  logic signed [WORD_W-1:0] inv_val;

  always_comb begin
    den     = dneg_r[ax_r] ? WORD_W'(-dir_r[ax_r]) : dir_r[ax_r];
    trial   = {rem_r, stp_r == '0};
    ge      = trial >= {1'b0, den};
    rem_nxt = ge ? WORD_W'(trial - {1'b0, den}) : trial[WORD_W-1:0];
    quo_fin = {quo_r[QW-2:0], ge};
    qx      = 64'(quo_fin);
    if (dzero_r[ax_r]) begin
      inv_val = '0;
    end else if (dneg_r[ax_r]) begin
      if ((|qx[63:32]) || (qx[31] && (|qx[30:0]))) begin
        inv_val = S32_MIN;
      end else begin
        inv_val = -$signed(qx[31:0]);
      end
    end else begin
      if (|qx[63:31]) begin
        inv_val = S32_MAX;
      end else begin
        inv_val = $signed(qx[31:0]);
      end
    end
  end

  // multiplier step
  logic [1:0]               m_ax;
  logic signed [WORD_W-1:0] bnd;
  logic signed [WORD_W:0]   diff;
  logic signed [64:0]       prod_nxt;
  logic signed [64:0]       sh;
  logic signed [WORD_W-1:0] t_sat;

  always_comb begin
    m_ax     = stp_r[2:1];
    bnd      = stp_r[0] ? $signed(cur_r.b[m_ax]) : $signed(cur_r.a[m_ax]);
    diff     = $signed({bnd[WORD_W-1], bnd}) - $signed({org_r[m_ax][WORD_W-1], org_r[m_ax]});
    prod_nxt = diff * inv_r[m_ax];
    sh       = prod_r >>> FRAC_BITS;
    if ((&sh[64:31]) || !(|sh[64:31])) begin
      t_sat = sh[WORD_W-1:0];
    end else begin
      t_sat = sh[64] ? S32_MIN : S32_MAX;
    end
  end

  // slab evaluation, first half
  logic signed [WORD_W-1:0] e_lo [3];
  logic signed [WORD_W-1:0] e_hi [3];
  logic [2:0]               e_out;
  logic signed [WORD_W-1:0] e_tn, e_tf;
  logic signed [WORD_W-1:0] bl, bh, ba, bb;

  always_comb begin
    e_out = '0;
    for (int i = 0; i < 3; i++) begin
      ba = $signed(cur_r.a[i]);
      bb = $signed(cur_r.b[i]);
      bl = (ba < bb) ? ba : bb;
      bh = (ba < bb) ? bb : ba;
      if (dzero_r[i]) begin
        e_lo[i]  = S32_MIN;
        e_hi[i]  = S32_MAX;
        e_out[i] = (org_r[i] < bl) || (org_r[i] > bh);
      end else begin
        e_lo[i] = (t_r[2*i] < t_r[2*i+1]) ? t_r[2*i] : t_r[2*i+1];
        e_hi[i] = (t_r[2*i] < t_r[2*i+1]) ? t_r[2*i+1] : t_r[2*i];
      end
    end
    e_tn = e_lo[0];
    e_tf = e_hi[0];
    for (int i = 1; i < 3; i++) begin
      if (e_lo[i] > e_tn) e_tn = e_lo[i];
      if (e_hi[i] < e_tf) e_tf = e_hi[i];
    end
  end

  // slab evaluation, second half
  logic signed [WORD_W-1:0] v_dist;
  logic [1:0]               v_ax;
  logic                     v_neg;
  logic [WORD_W:0]          v_gap;
  logic                     v_take;

  always_comb begin
    v_dist = tn_r[WORD_W-1] ? tf_r : tn_r;
    v_ax   = AXIS_NONE;
    v_neg  = 1'b0;
    for (int i = 2; i >= 0; i--) begin
      v_gap = $signed({tn_r[WORD_W-1], tn_r}) - $signed({lo_r[i][WORD_W-1], lo_r[i]});
      if (v_gap < (WORD_W+1)'(face_eps)) begin
        v_ax  = 2'(i);
        v_neg = ~dneg_r[i] & ~dzero_r[i];
      end
    end
    if (v_ax != AXIS_NONE && tn_r[WORD_W-1]) begin
      v_neg = ~v_neg;
    end
    v_take = ~miss_r && (!best_v_r || v_dist < best_d_r);
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          st_nxt = (q_data.kind == KIND_RAY) ? ST_DIV : ST_MUL;
        end
      end
      ST_DIV: begin
        if (stp_r == SW'(QW - 1) && ax_r == 2'd2) begin
          st_nxt = cur_r.last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_MUL: begin
        if (stp_r == SW'(6)) begin
          st_nxt = ST_EV1;
        end
      end
      ST_EV1: st_nxt = ST_EV2;
      ST_EV2: st_nxt = cur_r.last ? ST_EMIT : ST_IDLE;
      ST_EMIT: begin
        if (res_load) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    res_load = 1'b0;
    case (st_r)
      ST_IDLE: q_pop    = ~q_stat.empty;
      ST_EMIT: res_load = ~res_v_r | out_pop;
      default: begin
        q_pop    = 1'b0;
        res_load = 1'b0;
      end
    endcase
  end

  assign out_empty       = ~res_v_r;
  assign out_hit         = res_hit_r;
  assign out_distance    = res_d_r;
  assign out_normal_axis = res_ax_r;
  assign out_normal_sign = res_neg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      res_v_r    <= 1'b0;
      best_v_r   <= 1'b0;
      best_d_r   <= '0;
      best_ax_r  <= AXIS_NONE;
      best_neg_r <= 1'b0;
      dneg_r     <= '0;
      dzero_r    <= '1;
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
        inv_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (res_load) begin
        res_v_r <= 1'b1;
      end else if (out_pop) begin
        res_v_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (!q_stat.empty && q_data.kind == KIND_RAY) begin
            for (int i = 0; i < 3; i++) begin
              org_r[i] <= $signed(q_data.a[i]);
              dir_r[i] <= $signed(q_data.b[i]);
            end
            dneg_r     <= q_data.bneg;
            dzero_r    <= q_data.bzero;
            best_v_r   <= 1'b0;
            best_d_r   <= '0;
            best_ax_r  <= AXIS_NONE;
            best_neg_r <= 1'b0;
          end
        end
        ST_DIV: begin
          if (stp_r == SW'(QW - 1)) begin
            inv_r[ax_r] <= inv_val;
          end
        end
        ST_EV2: begin
          if (v_take) begin
            best_v_r   <= 1'b1;
            best_d_r   <= v_dist;
            best_ax_r  <= v_ax;
            best_neg_r <= v_neg;
          end
        end
        ST_EMIT: begin
          if (res_load) begin
            best_v_r   <= 1'b0;
            best_d_r   <= '0;
            best_ax_r  <= AXIS_NONE;
            best_neg_r <= 1'b0;
          end
        end
        default: begin
          best_v_r <= best_v_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ax_r  <= '0;
      stp_r <= '0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          ax_r  <= '0;
          stp_r <= '0;
        end
        ST_DIV: begin
          if (stp_r == SW'(QW - 1)) begin
            stp_r <= '0;
            ax_r  <= ax_r + 2'd1;
          end else begin
            stp_r <= stp_r + SW'(1);
          end
        end
        ST_MUL: stp_r <= stp_r + SW'(1);
        default: stp_r <= '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE && q_pop) begin
      cur_r <= q_data;
    end
    if (st_r == ST_IDLE || (st_r == ST_DIV && stp_r == SW'(QW - 1))) begin
      rem_r <= '0;
      quo_r <= '0;
    end else if (st_r == ST_DIV) begin
      rem_r <= rem_nxt;
      quo_r <= quo_fin;
    end
    if (st_r == ST_MUL) begin
      prod_r <= prod_nxt;
      if (stp_r != '0) begin
        t_r[3'(stp_r - SW'(1))] <= t_sat;
      end
    end
    if (st_r == ST_EV1) begin
      for (int i = 0; i < 3; i++) begin
        lo_r[i] <= e_lo[i];
      end
      tn_r   <= e_tn;
      tf_r   <= e_tf;
      miss_r <= (|e_out) || (e_tn > e_tf) || e_tf[WORD_W-1];
    end
    if (res_load) begin
      res_hit_r <= best_v_r;
      res_d_r   <= best_d_r[30:0];
      res_ax_r  <= best_ax_r;
      res_neg_r <= best_neg_r;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ray_box_list_closest_hit.sv =====
// Top level of the ray/box closest-hit block: front stage, queue, back sequencer.
// Depends on rbch_pkg, rbch_front, rbch_queue and rbch_back.
//
//  channel | ports                          | handshake
//  input   | in_kind, in_a*, in_b*, in_last | in_push / in_full
//  result  | out_hit .. out_normal_sign     | out_empty / out_pop
//  config  | cfg_face_epsilon               | cfg_valid / cfg_ready
//
// A box word takes fetch, ST_MUL on the shared 33x32 multiplier, slab evaluation
// in ST_EV1 and ST_EV2 in the back sequencer; a last word adds an emit step.
// A ray word runs the divider on each axis, one quotient bit per cycle.
// Reset is synchronous; the input stage and queue hold three words, so input
// stalls only when those are full, and a waiting result stalls only the emit step.
`timescale 1ns / 1ps
`default_nettype none
module ray_box_list_closest_hit import rbch_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_push,
  output logic                          in_full,
  input  wire logic                     in_kind,
  input  wire logic signed [WORD_W-1:0] in_ax,
  input  wire logic signed [WORD_W-1:0] in_ay,
  input  wire logic signed [WORD_W-1:0] in_az,
  input  wire logic signed [WORD_W-1:0] in_bx,
  input  wire logic signed [WORD_W-1:0] in_by,
  input  wire logic signed [WORD_W-1:0] in_bz,
  input  wire logic                     in_last,
  output logic                          out_empty,
  input  wire logic                     out_pop,
  output logic                          out_hit,
  output logic [30:0]                   out_distance,
  output logic [1:0]                    out_normal_axis,
  output logic                          out_normal_sign,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [15:0]              cfg_face_epsilon
);

  logic [15:0] eps_r;
  rbch_qstat_t q_stat;
  rbch_entry_t q_wdata, q_rdata;
  logic        q_push, q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      eps_r <= cfg_face_epsilon;
    end
  end

  rbch_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_kind (in_kind),
    .in_ax   (in_ax),
    .in_ay   (in_ay),
    .in_az   (in_az),
    .in_bx   (in_bx),
    .in_by   (in_by),
    .in_bz   (in_bz),
    .in_last (in_last),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  rbch_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  rbch_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_stat          (q_stat),
    .q_data          (q_rdata),
    .q_pop           (q_pop),
    .face_eps        (eps_r),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_hit         (out_hit),
    .out_distance    (out_distance),
    .out_normal_axis (out_normal_axis),
    .out_normal_sign (out_normal_sign)
  );

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking bench for ray_box_list_closest_hit: directed table then random ray/box lists.
// Depends on rbch_pkg and the RTL; holds its own slab-test predictor of the closest hit.
`timescale 1ns / 1ps
module tb;
  import rbch_pkg::*;

  localparam int FRAC = 16;
  localparam int SETTLE = 600;
  localparam int LIMIT = 3000000;

  typedef struct {
    logic kind;
    logic signed [31:0] a [3];
    logic signed [31:0] b [3];
    logic last;
  } word_t;

  typedef struct packed {
    logic hit;
    logic [30:0] dst;
    logic [1:0] axis;
    logic sign;
  } hit_t;

  typedef struct {
    word_t w;
    logic typed;
    hit_t res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_push = 0, in_kind = 0, in_last = 0;
  logic signed [31:0] in_ax = 0, in_ay = 0, in_az = 0, in_bx = 0, in_by = 0, in_bz = 0;
  logic out_pop = 0, cfg_valid = 0;
  logic [15:0] cfg_face_epsilon = 0;
  wire in_full, out_empty, out_hit, out_normal_sign, cfg_ready;
  wire [30:0] out_distance;
  wire [1:0] out_normal_axis;

  ray_box_list_closest_hit u_dut (
    .clk(clk), .rst_n(rst_n), .in_push(in_push), .in_full(in_full), .in_kind(in_kind),
    .in_ax(in_ax), .in_ay(in_ay), .in_az(in_az), .in_bx(in_bx), .in_by(in_by),
    .in_bz(in_bz), .in_last(in_last), .out_empty(out_empty), .out_pop(out_pop),
    .out_hit(out_hit), .out_distance(out_distance), .out_normal_axis(out_normal_axis),
    .out_normal_sign(out_normal_sign), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_face_epsilon(cfg_face_epsilon)
  );

  always #5 clk = ~clk;

  logic signed [31:0] org [3], dir [3], inv [3];
  logic best_ok, best_neg;
  logic signed [31:0] best_t;
  logic [1:0] best_ax;
  logic [15:0] eps;
  hit_t hits_q [$];
  int errors = 0, words = 0, results = 0, cycles = 0;
  int snd_idle = 0, rcv_idle = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
    if (v > 66'sh7FFF_FFFF) return S32_MAX;
    if (v < -66'sh8000_0000) return S32_MIN;
    return v[31:0];
  endfunction

  function automatic logic closest_hit(input word_t w, output hit_t r);
    logic signed [31:0] lo [3], hi [3];
    logic signed [31:0] tn, tf, t1, t2, d;
    logic signed [65:0] diff;
    logic miss, neg;
    logic [1:0] ax;
    r = '{hit: 0, dst: '0, axis: AXIS_NONE, sign: 0};
    if (w.kind == KIND_RAY) begin
      for (int i = 0; i < 3; i++) begin
        org[i] = w.a[i];
        dir[i] = w.b[i];
        inv[i] = (w.b[i] == 0) ? 32'sd0 : clamp32((66'sd1 <<< (2 * FRAC)) / 66'(w.b[i]));
      end
      best_ok = 0; best_t = 0; best_ax = AXIS_NONE; best_neg = 0;
      return w.last;
    end
    miss = 0;
    for (int i = 0; i < 3; i++) begin
      if (dir[i] == 0) begin
        if ((org[i] < w.a[i] && org[i] < w.b[i]) || (org[i] > w.a[i] && org[i] > w.b[i]))
          miss = 1;
        lo[i] = S32_MIN; hi[i] = S32_MAX;
      end else begin
        diff = 66'(w.a[i]) - 66'(org[i]);
        t1 = clamp32((diff * 66'(inv[i])) >>> FRAC);
        diff = 66'(w.b[i]) - 66'(org[i]);
        t2 = clamp32((diff * 66'(inv[i])) >>> FRAC);
        lo[i] = (t1 < t2) ? t1 : t2;
        hi[i] = (t1 < t2) ? t2 : t1;
      end
    end
    tn = lo[0]; tf = hi[0];
    for (int i = 1; i < 3; i++) begin
      if (lo[i] > tn) tn = lo[i];
      if (hi[i] < tf) tf = hi[i];
    end
    if (tn > tf || tf < 0) miss = 1;
    if (!miss) begin
      d = (tn < 0) ? tf : tn;
      ax = AXIS_NONE; neg = 0;
      for (int i = 2; i >= 0; i--)
        if (64'(tn) - 64'(lo[i]) < 64'(eps)) begin
          ax = 2'(i); neg = dir[i] > 0;
        end
      if (ax != AXIS_NONE && tn < 0) neg = !neg;
      if (!best_ok || d < best_t) begin
        best_ok = 1; best_t = d; best_ax = ax; best_neg = neg;
      end
    end
    if (w.last) begin
      if (best_ok) r = '{hit: 1, dst: best_t[30:0], axis: best_ax, sign: best_neg};
      best_ok = 0; best_t = 0; best_ax = AXIS_NONE; best_neg = 0;
    end
    return w.last;
  endfunction

  task automatic push_word(input word_t w, input logic typed = 0, input hit_t res = '0);
    hit_t r;
    while ($urandom_range(99) < snd_idle) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1; in_kind <= w.kind; in_last <= w.last;
    in_ax <= w.a[0]; in_ay <= w.a[1]; in_az <= w.a[2];
    in_bx <= w.b[0]; in_by <= w.b[1]; in_bz <= w.b[2];
    do @(posedge clk); while (in_full);
    words++;
    if (closest_hit(w, r)) hits_q = {hits_q, (typed ? res : r)};
  endtask

  task automatic drain(input int extra);
    while (hits_q.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_epsilon(input logic [15:0] v);
    in_push <= 0;
    drain(SETTLE);
    cfg_valid <= 1; cfg_face_epsilon <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    eps = v;
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    hit_t e;
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        results++;
        if (hits_q.size() == 0) begin
          errors++;
          $error("unexpected result word");
        end else begin
          e = hits_q.pop_front();
          if (out_hit !== e.hit) begin
            errors++; $error("hit exp %0d got %0d", e.hit, out_hit);
          end
          if (out_distance !== e.dst) begin
            errors++; $error("distance exp %h got %h", e.dst, out_distance);
          end
          if (out_normal_axis !== e.axis) begin
            errors++; $error("normal_axis exp %0d got %0d", e.axis, out_normal_axis);
          end
          if (out_normal_sign !== e.sign) begin
            errors++; $error("normal_sign exp %0d got %0d", e.sign, out_normal_sign);
          end
        end
      end
      out_pop <= ($urandom_range(99) >= rcv_idle);
    end
  end

  function automatic word_t mk(input logic k, input logic signed [31:0] a0, a1, a2,
                               input logic signed [31:0] b0, b1, b2, input logic l);
    word_t w;
    w.kind = k; w.last = l;
    w.a = '{a0, a1, a2}; w.b = '{b0, b1, b2};
    return w;
  endfunction

  function automatic logic signed [31:0] rnd_dir();
    case ($urandom_range(7))
      0: return 0;
      1: return $urandom_range(1) ? S32_MAX : S32_MIN;
      2: return $urandom_range(1) ? 32'sd1 : -32'sd1;
      3: return $urandom;
      default: return $signed($urandom_range(1 << 18)) - (1 << 17);
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_bound(input logic signed [31:0] o);
    if ($urandom_range(9) == 0) return $urandom;
    return o + $signed($urandom_range(1 << 22)) - (1 << 21);
  endfunction

  task automatic random_phase(input int n);
    word_t w;
    int k, nb;
    k = 0;
    while (k < n) begin
      if ($urandom_range(9) == 0) begin
        w = mk(1'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
               1'($urandom));
        push_word(w); k++;
      end else begin
        nb = $urandom_range(5);
        w = mk(KIND_RAY, $signed($urandom_range(1 << 22)) - (1 << 21),
               $signed($urandom_range(1 << 22)) - (1 << 21), $urandom_range(1) ? $urandom : 0,
               rnd_dir(), rnd_dir(), rnd_dir(), nb == 0);
        push_word(w); k++;
        for (int j = 0; j < nb; j++) begin
          w = mk(KIND_BOX, rnd_bound(org[0]), rnd_bound(org[1]), rnd_bound(org[2]),
                 rnd_bound(org[0]), rnd_bound(org[1]), rnd_bound(org[2]), j == nb - 1);
          push_word(w); k++;
        end
      end
    end
  endtask

  row_t plan [] = '{
    '{mk(KIND_RAY, 0, 0, 0, 0, 0, 0, 1), 1, '{0, 31'd0, AXIS_NONE, 0}},
    '{mk(KIND_BOX, 5, 5, 5, 6, 6, 6, 1), 1, '{0, 31'd0, AXIS_NONE, 0}},
    '{mk(KIND_BOX, -1, -1, -1, 1, 1, 1, 1), 0, '0},
    '{mk(KIND_RAY, 0, 0, 0, 32'sh1_0000, 0, 0, 0), 0, '0},
    '{mk(KIND_BOX, 32'sh2_0000, -1, -1, 32'sh3_0000, 1, 1, 0), 0, '0},
    '{mk(KIND_BOX, 32'sh3_0000, -1, -1, 32'sh1_0000, 1, 1, 0), 0, '0},
    '{mk(KIND_BOX, 32'sh5_0000, 4, 4, 32'sh6_0000, 9, 9, 1), 0, '0},
    '{mk(KIND_BOX, -32'sh1_0000, -1, -1, 32'sh1_0000, 1, 1, 1), 0, '0},
    '{mk(KIND_BOX, -32'sh3_0000, -1, -1, -32'sh2_0000, 1, 1, 1), 1, '{0, 31'd0, AXIS_NONE, 0}},
    '{mk(KIND_RAY, 0, 0, 0, -32'sh1_0000, 32'sh8000, 32'sh2_0000, 0), 0, '0},
    '{mk(KIND_BOX, -32'sh8_0000, 32'sh1_0000, 32'sh1_0000, -32'sh1_0000, 32'sh4_0000,
         32'sh4_0000, 1), 0, '0},
    '{mk(KIND_RAY, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 1, -1, 32'sh7FFF_FFFF, 0), 0, '0},
    '{mk(KIND_BOX, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
         32'sh8000_0000, 32'sh7FFF_FFFF, 1), 0, '0},
    '{mk(KIND_RAY, -32'sd1, -32'sd1, -32'sd1, 32'sh8000_0000, 0, 32'sh8000_0000, 0), 0, '0},
    '{mk(KIND_BOX, 32'sh7FFF_FFFF, -2, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 32'sh8000_0000, 0),
      0, '0},
    '{mk(KIND_BOX, 0, 0, 0, 0, 0, 0, 1), 0, '0},
    '{mk(KIND_RAY, 1, 2, 3, 4, 5, 6, 1), 1, '{0, 31'd0, AXIS_NONE, 0}}
  };

  initial begin
    eps = 1;
    for (int i = 0; i < 3; i++) begin
      org[i] = 0; dir[i] = 0; inv[i] = 0;
    end
    best_ok = 0; best_t = 0; best_ax = AXIS_NONE; best_neg = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    drain(SETTLE);
    foreach (plan[i]) push_word(plan[i].w, plan[i].typed, plan[i].res);
    write_epsilon(16'hFFFF);
    foreach (plan[i]) push_word(plan[i].w);
    write_epsilon(16'h0000);
    snd_idle = 36; rcv_idle = 48;
    random_phase(150);
    in_push <= 0;
    drain(SETTLE);
    random_phase(150);
    write_epsilon(16'($urandom));
    snd_idle = 48; rcv_idle = 36;
    random_phase(300);
    write_epsilon(16'd1);
    snd_idle = 0; rcv_idle = 0;
    random_phase(300);
    in_push <= 0;
    drain(SETTLE);
    $display("%0d words sent, %0d results checked over five epsilon settings", words, results);
    if (errors == 0 && hits_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

// ===== ray_box_list_closest_hit.f =====
hdl/rbch_pkg.sv
hdl/rbch_front.sv
hdl/rbch_queue.sv
hdl/rbch_back.sv
hdl/ray_box_list_closest_hit.sv
verif/tb.sv
